### sv/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared constants and types for the trial-division prime test.
// ----------------------------------------------------------------------------
`default_nettype none

package trd_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef struct packed {
    logic done;
    logic zero;
  } trd_rem_status_t;

endpackage

`default_nettype wire

### sv/trd_rem.sv
// ----------------------------------------------------------------------------
// trd_rem
// Serial remainder unit: restoring division, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_rem import trd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DATA_WIDTH-1:0] dividend,
  input  wire logic [DATA_WIDTH-1:0] divisor,
  output trd_rem_status_t            status
);

  localparam int CW = $clog2(DATA_WIDTH + 1);
  localparam logic [CW-1:0] CNT_LOAD = CW'(DATA_WIDTH);
  localparam logic [CW-1:0] CNT_ONE  = CW'(1);

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;
  logic [DATA_WIDTH-1:0] dvs;
  logic [CW-1:0]         cnt;
  logic                  done;
  logic [DATA_WIDTH:0]   trial;
  logic [DATA_WIDTH:0]   diff;

  assign trial = {rem, quo[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (cnt != '0) begin
      quo <= {quo[DATA_WIDTH-2:0], 1'b0};
      if (!diff[DATA_WIDTH]) begin
        rem <= diff[DATA_WIDTH-1:0];
      end else begin
        rem <= trial[DATA_WIDTH-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else if (start) begin
      cnt  <= CNT_LOAD;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_ONE);
      if (cnt != '0) begin
        cnt <= cnt - CNT_ONE;
      end
    end
  end

  assign status.done = done;
  assign status.zero = (rem == '0);

endmodule

`default_nettype wire

### sv/trial_division_prime_test.sv
// ----------------------------------------------------------------------------
// trial_division_prime_test
// Primality test by trial division over a serial remainder unit.
// ----------------------------------------------------------------------------
//   channel   dir   fields (tdata, low bit first)
//   s_*       in    value  [DATA_WIDTH-1:0], signed, zero padded to bytes
//   m_*       out   is_prime [0], zero padded to 8 bits
//
// Each divisor takes DATA_WIDTH remainder steps in trd_rem plus one bound
// check and one hand-off. Negative values and values of 1 or less skip the
// divisor search. One request is worked at a time; a new one is taken once
// the result has been moved to the output register, which holds while
// m_tready is low. Reset is synchronous and clears only control state.
// ----------------------------------------------------------------------------
`default_nettype none

module trial_division_prime_test import trd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((DATA_WIDTH+7)/8)*8-1:0]     s_tdata,   // value
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [7:0]                               m_tdata    // is_prime
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_DIV    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]            state;
  logic [DATA_WIDTH-1:0] val;
  logic [DATA_WIDTH-1:0] dvs;
  logic [DATA_WIDTH:0]   sq;
  logic                  res;
  logic                  rem_start;
  trd_rem_status_t       rem_st;
  logic [DATA_WIDTH-1:0] in_val;

  assign in_val    = s_tdata[DATA_WIDTH-1:0];
  assign s_tready  = (state == S_IDLE);
  assign rem_start = (state == S_CHECK) && (sq <= {1'b0, val});

  trd_rem #(.DATA_WIDTH(DATA_WIDTH)) u_rem (
    .clk      (clk),
    .rst      (rst),
    .start    (rem_start),
    .dividend (val),
    .divisor  (dvs),
    .status   (rem_st)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && (state != S_FINISH)) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            val <= in_val;
            dvs <= DATA_WIDTH'(2);
            sq  <= (DATA_WIDTH + 1)'(4);
            if (in_val[DATA_WIDTH-1] || (in_val <= DATA_WIDTH'(1))) begin
              res   <= 1'b0;
              state <= S_FINISH;
            end else begin
              state <= S_CHECK;
            end
          end
        end
        S_CHECK: begin
          if (rem_start) begin
            state <= S_DIV;
          end else begin
            res   <= 1'b1;
            state <= S_FINISH;
          end
        end
        S_DIV: begin
          if (rem_st.done) begin
            if (rem_st.zero) begin
              res   <= 1'b0;
              state <= S_FINISH;
            end else begin
              dvs   <= dvs + DATA_WIDTH'(1);
              sq    <= sq + {dvs, 1'b1};
              state <= S_CHECK;
            end
          end
        end
        S_FINISH: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {7'd0, res};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### sv/trd_checker.sv
// ----------------------------------------------------------------------------
// trd_checker
// Port-level checks for the prime test, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module trd_checker import trd_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            s_tvalid,
  input wire logic                            s_tready,
  input wire logic                            m_tvalid,
  input wire logic                            m_tready,
  input wire logic [7:0]                      m_tdata
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("reset left the block busy or a result pending");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken before a result");

  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[7:1] == 7'd0))
    else $error("padding bits of result not zero");

endmodule

bind trial_division_prime_test trd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_trd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for trial_division_prime_test. A driver sends signed
// values from a pending queue, a trial-division predictor computes the
// primality flag of each accepted request, and a monitor compares every
// result with the oldest expected flag. Both sides idle at random, except
// for a stretch of the run where they stream back to back.
// ----------------------------------------------------------------------------
module tb_top;
  import trd_pkg::*;

  localparam int DATA_W     = DATA_WIDTH_DEF;
  localparam int TDATA_W    = ((DATA_W + 7) / 8) * 8;
  localparam int STALL_PCT  = 19;
  localparam int QUIET_LO   = 40;
  localparam int QUIET_HI   = 65;
  localparam int STALL_MAX  = 200000;
  localparam int DRAIN_CYC  = 200;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              is_prime;
  } prime_expect_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;

  logic [DATA_W-1:0]  value_q[$];
  prime_expect_t      prime_expect_q[$];
  int                 requests_sent = 0;
  int                 results_checked = 0;
  int                 primes_seen = 0;
  int                 negatives_sent = 0;
  int                 errors = 0;
  int                 stall_cycles = 0;

  trial_division_prime_test #(
    .DATA_WIDTH(DATA_W)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic bit trial_divide(logic [DATA_W-1:0] v);
    longint unsigned n;
    longint unsigned d;
    n = longint'(v);
    if (v[DATA_W-1]) return 1'b0;
    if (n <= 1) return 1'b0;
    for (d = 2; d * d <= n; d++) begin
      if (n % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit quiet_window();
    return requests_sent >= QUIET_LO && requests_sent < QUIET_HI;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        prime_expect_q.push_back('{value: s_tdata[DATA_W-1:0],
                                   is_prime: trial_divide(s_tdata[DATA_W-1:0])});
        if (s_tdata[DATA_W-1]) negatives_sent++;
        requests_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (value_q.size() != 0 &&
            (quiet_window() || $urandom_range(0, 99) >= STALL_PCT)) begin
          s_tvalid <= 1'b1;
          s_tdata  <= TDATA_W'(value_q.pop_front());
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    prime_expect_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= quiet_window() || $urandom_range(0, 99) >= STALL_PCT;
      if (m_tvalid && m_tready) begin
        if (prime_expect_q.size() == 0) begin
          $error("unexpected result: is_prime actual %0b", m_tdata[0]);
          errors++;
        end else begin
          exp_r = prime_expect_q.pop_front();
          if (m_tdata[0] !== exp_r.is_prime) begin
            $error("value %0d: is_prime expected %0b actual %0b",
                   $signed(exp_r.value), exp_r.is_prime, m_tdata[0]);
            errors++;
          end
          if (exp_r.is_prime) primes_seen++;
          results_checked++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == STALL_MAX) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sel;
    int unsigned p;
    logic [DATA_W-1:0] directed[$];

    directed = '{32'h8000_0000, 32'hFFFF_FFFF, -32'sd7, 32'd0, 32'd1, 32'd2, 32'd3,
                 32'd4, 32'd5, 32'd9, 32'd25, 32'd49, 32'd97, 32'd121, 32'd65537,
                 32'd1018081, 32'd1048573, 32'd1048576, 32'h5555_5555,
                 32'hAAAA_AAAA, 32'h7FFF_FFFE, 32'h7FFF_FFFD};
    foreach (directed[i]) value_q.push_back(directed[i]);

    for (int i = 0; i < 78; i++) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        value_q.push_back(DATA_W'($urandom_range(0, 5000)));
      end else if (sel < 70) begin
        value_q.push_back(DATA_W'($urandom_range(5001, 1 << 18)));
      end else if (sel < 80) begin
        value_q.push_back(DATA_W'($urandom) | 32'h8000_0000);
      end else if (sel < 90) begin
        value_q.push_back(DATA_W'($urandom) & 32'h7FFF_FFFE);
      end else begin
        // multiple of a small odd prime, so the search ends early
        case ($urandom_range(0, 4))
          0: p = 3;
          1: p = 5;
          2: p = 7;
          3: p = 11;
          default: p = 13;
        endcase
        value_q.push_back(DATA_W'(p * $urandom_range(1, 32'h7FFF_FFFF / p)));
      end
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (value_q.size() != 0 || s_tvalid || prime_expect_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Tested %0d values (%0d negative), %0d results checked, %0d prime.",
             requests_sent, negatives_sent, results_checked, primes_seen);
    $display("Mismatches: %0d", errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
